[hw/rtl/psfb_pkg.sv]
package psfb_pkg;

    // Framing characters.
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;

    // Station number after reset.
    localparam logic [7:0] STATION_RESET = 8'h01;

    // Default depth of the queue between the front and back parts (at least 2).
    localparam int QUEUE_DEPTH = 4;

    // One classified payload byte, as handed from the front to the back part.
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic [7:0] stn_hi;
        logic [7:0] stn_lo;
        logic [7:0] sum;
    } psfb_entry_t;

    // Write side of the queue.
    typedef struct packed {
        logic        valid;
        psfb_entry_t entry;
    } psfb_push_t;

    // Read side of the queue: the oldest entry, shown ahead of the pop.
    typedef struct packed {
        logic        valid;
        psfb_entry_t entry;
    } psfb_head_t;

    // Fill status of the queue.
    typedef struct packed {
        logic full;
        logic empty;
    } psfb_q_stat_t;

    // Uppercase ASCII hex digit of one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10)
        begin
            r = 8'h30 + {4'h0, nib};
        end
        else
        begin
            r = 8'h37 + {4'h0, nib};
        end
        return r;
    endfunction

endpackage

[hw/rtl/psfb_ifs.sv]
// Payload channel: one command byte per beat.
interface psfb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_last;

    modport source (output valid, output payload_byte, output payload_last, input ready);
    modport sink (input valid, input payload_byte, input payload_last, output ready);
endinterface

// Frame channel: one frame byte per beat.
interface psfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

[hw/rtl/plc_serial_frame_builder.sv]
// Channel   Direction  Beat contents
// payload   in         payload_byte[7:0], payload_last
// frame     out        frame_byte[7:0], frame_end (set on ETX)
// cfg       in         cfg_we, cfg_wdata[7:0] = station_number
//
// Frame beats leave at one per cycle while entries wait and the frame side is ready;
// a middle payload beat yields one frame beat, an opening beat four, a closing beat
// four, a lone beat seven, set by the back sequencer. A payload beat passes through
// the entry queue and the output register on its way to the frame port. Reset sets
// the station number to 1, closes any frame and empties the queue. The payload side
// stalls only when the queue of DEPTH entries is full; a stalled frame beat holds in
// the output register.
module plc_serial_frame_builder #(
    parameter int DEPTH = psfb_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    psfb_in_if.sink    payload,
    psfb_out_if.source frame
);

    logic [7:0]             station_number_reg;
    psfb_pkg::psfb_push_t   push;
    psfb_pkg::psfb_head_t   head;
    psfb_pkg::psfb_q_stat_t q_stat;
    logic                   pop;

    // Station number register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_number_reg <= psfb_pkg::STATION_RESET;
        end
        else if (cfg_we)
        begin
            station_number_reg <= cfg_wdata;
        end
    end

    // Front part: accepts payload beats and works out header and checksum.
    psfb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .station_number (station_number_reg),
        .payload        (payload),
        .q_stat         (q_stat),
        .push           (push)
    );

    // Entry queue between the two parts.
    psfb_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .q_stat (q_stat)
    );

    // Back part: emits the frame beats of each entry.
    psfb_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .frame (frame)
    );

    // The end mark rides only on the ETX byte.
    a_end_is_etx: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.frame_end) |-> (frame.frame_byte == psfb_pkg::CH_ETX))
        else $error("frame_end set on a byte other than ETX");

    // An accepted beat is held in the queue in the following cycle.
    a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (payload.valid && payload.ready) |=> !q_stat.empty)
        else $error("accepted payload beat missing from queue");

    // The queue is never popped while empty.
    a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

endmodule

[hw/rtl/psfb_front.sv]
module psfb_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            station_number,
    psfb_in_if.sink               payload,
    input  psfb_pkg::psfb_q_stat_t q_stat,
    output psfb_pkg::psfb_push_t  push
);

    logic       inside_frame_reg;
    logic       inside_frame_next;
    logic [7:0] running_sum_reg;
    logic [7:0] running_sum_next;
    logic       accept;
    logic [7:0] stn_hi;
    logic [7:0] stn_lo;
    logic [7:0] base_sum;
    logic [7:0] new_sum;

    // A beat is taken whenever the queue has room.
    assign payload.ready = !q_stat.full;
    assign accept        = payload.valid && payload.ready;

    // Header digits come from the station number as it stands when a frame opens.
    assign stn_hi   = psfb_pkg::hex_char(station_number[7:4]);
    assign stn_lo   = psfb_pkg::hex_char(station_number[3:0]);
    assign base_sum = inside_frame_reg ? running_sum_reg
                                       : 8'(psfb_pkg::CH_STX + stn_hi + stn_lo);
    assign new_sum  = base_sum + payload.payload_byte;

    // Classified entry for the back part.
    always_comb
    begin
        push.valid        = accept;
        push.entry.data   = payload.payload_byte;
        push.entry.first  = !inside_frame_reg;
        push.entry.last   = payload.payload_last;
        push.entry.stn_hi = stn_hi;
        push.entry.stn_lo = stn_lo;
        push.entry.sum    = new_sum;
    end

    // Frame state advances on each accepted beat.
    always_comb
    begin
        inside_frame_next = inside_frame_reg;
        running_sum_next  = running_sum_reg;
        if (accept)
        begin
            inside_frame_next = !payload.payload_last;
            running_sum_next  = payload.payload_last ? 8'h00 : new_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_frame_reg <= 1'b0;
            running_sum_reg  <= 8'h00;
        end
        else
        begin
            inside_frame_reg <= inside_frame_next;
            running_sum_reg  <= running_sum_next;
        end
    end

endmodule

[hw/rtl/psfb_queue.sv]
module psfb_queue #(
    parameter int DEPTH = psfb_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  psfb_pkg::psfb_push_t   push,
    input  logic                   pop,
    output psfb_pkg::psfb_head_t   head,
    output psfb_pkg::psfb_q_stat_t q_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    psfb_pkg::psfb_entry_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push.valid && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;

    assign head.valid = !q_stat.empty;
    assign head.entry = mem[rd_ptr_reg];

    // Pointer and fill bookkeeping, wrapping at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

[hw/rtl/psfb_back.sv]
module psfb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  psfb_pkg::psfb_head_t head,
    output logic                 pop,
    psfb_out_if.source           frame
);

    typedef enum logic [2:0] {
        PH_START,
        PH_STX,
        PH_STN_HI,
        PH_STN_LO,
        PH_DATA,
        PH_SUM_HI,
        PH_SUM_LO,
        PH_ETX
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    phase_t     cur_phase;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_end_reg;
    logic       step;
    logic       done;
    logic [7:0] beat_byte;
    logic       beat_end;

    assign frame.valid      = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.frame_end  = out_end_reg;

    // A new beat is made when an entry waits and the output register is empty or being taken.
    assign step = head.valid && (!out_valid_reg || frame.ready);
    assign pop  = step && done;

    // Where in the current entry the sequencer stands.
    always_comb
    begin
        if (phase_reg == PH_START)
        begin
            cur_phase = head.entry.first ? PH_STX : PH_DATA;
        end
        else
        begin
            cur_phase = phase_reg;
        end
    end

    // Byte of the current phase and the phase after it.
    always_comb
    begin
        beat_byte  = head.entry.data;
        beat_end   = 1'b0;
        done       = 1'b0;
        phase_next = PH_START;
        case (cur_phase)
            PH_STX:
            begin
                beat_byte  = psfb_pkg::CH_STX;
                phase_next = PH_STN_HI;
            end
            PH_STN_HI:
            begin
                beat_byte  = head.entry.stn_hi;
                phase_next = PH_STN_LO;
            end
            PH_STN_LO:
            begin
                beat_byte  = head.entry.stn_lo;
                phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                beat_byte = head.entry.data;
                if (head.entry.last)
                begin
                    phase_next = PH_SUM_HI;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            PH_SUM_HI:
            begin
                beat_byte  = psfb_pkg::hex_char(head.entry.sum[7:4]);
                phase_next = PH_SUM_LO;
            end
            PH_SUM_LO:
            begin
                beat_byte  = psfb_pkg::hex_char(head.entry.sum[3:0]);
                phase_next = PH_ETX;
            end
            PH_ETX:
            begin
                beat_byte = psfb_pkg::CH_ETX;
                beat_end  = 1'b1;
                done      = 1'b1;
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase
    end

    // Sequencer state and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'h00;
            out_end_reg   <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg     <= phase_next;
                out_valid_reg <= 1'b1;
                out_byte_reg  <= beat_byte;
                out_end_reg   <= beat_end;
            end
            else if (frame.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[bench/plc_serial_frame_builder_tb.sv]
module plc_serial_frame_builder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // One payload beat waiting to be offered to the block.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } payload_beat_t;

    // One frame beat the block is expected to produce.
    typedef struct {
        logic [7:0] data;
        logic       eof;
    } frame_beat_t;

    localparam int LONG_HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES     = 4;
    localparam int TAIL_CYCLES      = 20;
    localparam int PHASE_ITEMS      = 40;

    // Uppercase ASCII hex digits, most significant byte first.
    localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    psfb_in_if  payload_ch ();
    psfb_out_if frame_ch ();

    plc_serial_frame_builder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .payload   (payload_ch),
        .frame     (frame_ch)
    );

    payload_beat_t payload_q[$];
    frame_beat_t   frame_q[$];

    // Shadow of the block's register and framing state.
    logic [7:0] station_shadow = psfb_pkg::STATION_RESET;
    logic       frame_open     = 1'b0;
    logic [7:0] frame_sum      = 8'h00;

    int  error_count    = 0;
    int  src_gap        = 0;
    int  sink_gap       = 0;
    int  hold_left      = 0;
    bit  long_hold_done = 1'b0;
    logic idling_on     = 1'b1;
    logic long_hold_req = 1'b0;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
        return HEX_DIGITS[8 * (15 - nib) +: 8];
    endfunction

    function automatic void push_frame_beat(input logic [7:0] b, input logic eof);
        frame_beat_t fb;
        fb.data = b;
        fb.eof  = eof;
        frame_q.push_back(fb);
    endfunction

    // A beat that counts toward the checksum.
    function automatic void push_summed_beat(input logic [7:0] b);
        push_frame_beat(b, 1'b0);
        frame_sum = frame_sum + b;
    endfunction

    // Expected frame beats for one accepted payload beat.
    function automatic void predict_frame_beats(input payload_beat_t item);
        if (!frame_open)
        begin
            frame_sum = 8'h00;
            push_summed_beat(psfb_pkg::CH_STX);
            push_summed_beat(ascii_hex(station_shadow[7:4]));
            push_summed_beat(ascii_hex(station_shadow[3:0]));
            frame_open = 1'b1;
        end
        push_summed_beat(item.data);
        if (item.last)
        begin
            push_frame_beat(ascii_hex(frame_sum[7:4]), 1'b0);
            push_frame_beat(ascii_hex(frame_sum[3:0]), 1'b0);
            push_frame_beat(psfb_pkg::CH_ETX, 1'b1);
            frame_open = 1'b0;
            frame_sum  = 8'h00;
        end
    endfunction

    // Payload driver: offers the oldest pending beat, may idle between beats while idling is on.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_ch.valid        <= 1'b0;
            payload_ch.payload_byte <= 8'h00;
            payload_ch.payload_last <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (payload_ch.valid && payload_ch.ready)
            begin
                predict_frame_beats(payload_q.pop_front());
            end
            if (!payload_ch.valid || payload_ch.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap = src_gap - 1;
                    payload_ch.valid <= 1'b0;
                end
                else if (idling_on && $urandom_range(0, 4) == 0)
                begin
                    src_gap = $urandom_range(0, 7);
                    payload_ch.valid <= 1'b0;
                end
                else if (payload_q.size() > 0)
                begin
                    payload_ch.valid        <= 1'b1;
                    payload_ch.payload_byte <= payload_q[0].data;
                    payload_ch.payload_last <= payload_q[0].last;
                end
                else
                begin
                    payload_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off of the frame side, started once when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            long_hold_done = 1'b1;
            hold_left <= LONG_HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Frame monitor: checks each accepted beat and drives ready.
    always @(posedge clk or negedge rst_n)
    begin
        frame_beat_t exp_beat;
        if (!rst_n)
        begin
            frame_ch.ready <= 1'b0;
            sink_gap  = 0;
        end
        else
        begin
            if (frame_ch.valid && frame_ch.ready)
            begin
                if (frame_q.size() == 0)
                begin
                    error_count = error_count + 1;
                    $display("%0t: unexpected frame beat: byte=%h end=%b",
                             $time, frame_ch.frame_byte, frame_ch.frame_end);
                end
                else
                begin
                    exp_beat = frame_q.pop_front();
                    if (exp_beat.data !== frame_ch.frame_byte ||
                        exp_beat.eof !== frame_ch.frame_end)
                    begin
                        error_count = error_count + 1;
                        $display("%0t: expected byte=%h end=%b, actual byte=%h end=%b",
                                 $time, exp_beat.data, exp_beat.eof,
                                 frame_ch.frame_byte, frame_ch.frame_end);
                    end
                end
            end

            if (hold_left > 0)
            begin
                frame_ch.ready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap = sink_gap - 1;
                frame_ch.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 3) == 0)
            begin
                sink_gap = $urandom_range(0, 7);
                frame_ch.ready <= 1'b0;
            end
            else
            begin
                frame_ch.ready <= 1'b1;
            end
        end
    end

    task automatic queue_beat(input logic [7:0] data, input logic last);
        payload_beat_t item;
        item.data = data;
        item.last = last;
        payload_q.push_back(item);
    endtask

    // Payload byte with a bias toward framing characters and the extremes.
    function automatic logic [7:0] pick_payload_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0: b = 8'h00;
            1: b = psfb_pkg::CH_STX;
            2: b = psfb_pkg::CH_ETX;
            3: b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // Random frames, mostly short; the last one may stay open at the phase end.
    task automatic queue_random_frames(input int n_items);
        int remaining;
        int len;
        remaining = n_items;
        while (remaining > 0)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                len = $urandom_range(1, 4);
            end
            else
            begin
                len = $urandom_range(5, 12);
            end
            for (int i = 0; i < len && remaining > 0; i++)
            begin
                queue_beat(pick_payload_byte(), i == len - 1);
                remaining = remaining - 1;
            end
        end
    endtask

    // Wait until every beat is accepted and every expected beat has arrived.
    task automatic wait_for_drain();
        while (payload_q.size() != 0 || payload_ch.valid || frame_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_station(input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        station_shadow = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Reset, directed frames, then random phases.
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Lone-byte frames at the byte extremes, with the reset station number.
        queue_beat(8'h00, 1'b1);
        queue_beat(8'hFF, 1'b1);
        // Framing characters inside a payload pass through unchanged.
        queue_beat(psfb_pkg::CH_STX, 1'b0);
        queue_beat(psfb_pkg::CH_ETX, 1'b0);
        queue_beat(8'h00, 1'b0);
        queue_beat(8'hFF, 1'b1);
        queue_beat(8'hA5, 1'b0);
        queue_beat(8'h5A, 1'b1);
        queue_beat(8'h41, 1'b0);
        wait_for_drain();

        // A station change while a frame is open applies to the next frame only.
        write_station(8'hFF);
        queue_beat(8'h42, 1'b1);
        queue_beat(8'h43, 1'b1);
        queue_beat(8'h30, 1'b0);
        queue_beat(8'h39, 1'b1);
        wait_for_drain();

        write_station(8'h00);
        queue_beat(8'hFF, 1'b0);
        queue_beat(8'hFF, 1'b0);
        queue_beat(8'hFF, 1'b1);
        queue_beat(psfb_pkg::CH_ETX, 1'b1);
        wait_for_drain();

        write_station(8'h9A);
        queue_beat(8'h7E, 1'b0);
        queue_beat(8'h81, 1'b1);
        queue_beat(8'h00, 1'b0);
        wait_for_drain();

        // Random phases, each with its own station number.
        for (int phase = 0; phase < 5; phase++)
        begin
            write_station(8'($urandom_range(0, 255)));
            if (phase == 4)
            begin
                idling_on <= 1'b0;
            end
            queue_random_frames(PHASE_ITEMS);
            if (phase == 1)
            begin
                // Hold the frame side off so the block fills up and stalls.
                long_hold_req <= 1'b1;
            end
            wait_for_drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/psfb_pkg.sv
hw/rtl/psfb_ifs.sv
hw/rtl/psfb_front.sv
hw/rtl/psfb_queue.sv
hw/rtl/psfb_back.sv
hw/rtl/plc_serial_frame_builder.sv
bench/plc_serial_frame_builder_tb.sv
